### hw/rtl/rkst_pkg.sv
// Package for the refcounted keyed slot table: sizes, codes, beat types.
// No dependencies.
package rkst_pkg;
    localparam int SLOTS     = 64;
    localparam int KEY_BITS  = 64;
    localparam int REF_BITS  = 16;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int ENT_W     = KEY_BITS + REF_BITS;

    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic [63:0]      key;
        logic [IDX_W-1:0] slot_index;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0]    slot;
        logic                created;
        logic                freed;
        logic [REF_BITS-1:0] ref_count;
        logic [CNT_W-1:0]    live_slots;
        logic [1:0]          status;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_POP, S_ALLOC, S_REL, S_OUT
    } t_state;
endpackage

### hw/rtl/refcounted_keyed_slot_table.sv
// Refcounted keyed slot table top level.
// Depends on rkst_pkg and rkst_ram.
//
// Each slot's key and count live in one RAM (registered read); the LIFO
// free stack lives in a second RAM. A slot below the high-water mark is live when
// its stored count is nonzero: every slot below the mark has been written since the
// last clear, and a freed slot is written back with count zero, so clear and reset
// only need to drop the mark and the stack depth. An acquire scans slots
// 0..high_water-1 one per cycle through the entry RAM port and stops at the first
// live match; on a miss it passes S_POP when it reuses a freed slot, then S_ALLOC.
// A release passes S_REL and a clear goes straight to S_OUT.
// One beat is worked at a time; the result register holds the beat until taken.
module refcounted_keyed_slot_table
    import rkst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);
    localparam logic [REF_BITS-1:0] REF_MAX = '1;

    t_state r_state, n_state;
    t_in    r_in;
    t_out   r_out, n_out;
    logic [CNT_W-1:0] r_fdepth, n_fdepth, r_hw, n_hw, r_total, n_total;
    logic [CNT_W-1:0] r_scan, n_scan;   // address issued last cycle

    // memory ports
    logic             ent_we;
    logic [IDX_W-1:0] ent_waddr, ent_raddr;
    logic [ENT_W-1:0] ent_wdata, ent_rdata;
    logic             fs_we;
    logic [IDX_W-1:0] fs_waddr, fs_raddr;
    logic [IDX_W-1:0] fs_wdata, fs_rdata;

    rkst_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_ent (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(ent_waddr), .i_wdata(ent_wdata),
        .i_raddr(ent_raddr), .o_rdata(ent_rdata));
    rkst_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_fs (
        .i_clk(i_clk), .i_we(fs_we), .i_waddr(fs_waddr), .i_wdata(fs_wdata),
        .i_raddr(fs_raddr), .o_rdata(fs_rdata));

    logic [KEY_BITS-1:0] rd_key;
    logic [REF_BITS-1:0] rd_refs;
    logic [IDX_W-1:0]    scan_idx;
    logic                hit;
    assign rd_key   = ent_rdata[ENT_W-1 -: KEY_BITS];
    assign rd_refs  = ent_rdata[REF_BITS-1:0];
    assign scan_idx = r_scan[IDX_W-1:0];
    // live = below the mark with a nonzero count
    assign hit = (r_scan < r_hw) && (rd_refs != '0)
              && (rd_key == r_in.key[KEY_BITS-1:0]);

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_data  = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) begin
                unique case (i_data.op)
                    OP_ACQUIRE: n_state = S_SCAN;
                    OP_RELEASE: n_state = S_REL;
                    default:    n_state = S_OUT;
                endcase
            end
            S_SCAN: begin
                if (hit) n_state = S_OUT;
                else if (r_scan + 1'b1 >= r_hw || r_scan + 1'b1 >= CNT_W'(SLOTS))
                    n_state = (r_fdepth != '0) ? S_POP : S_ALLOC;
            end
            S_POP:   n_state = S_ALLOC;
            S_ALLOC: n_state = S_OUT;
            S_REL:   n_state = S_OUT;
            S_OUT:   if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_out = r_out; n_fdepth = r_fdepth; n_hw = r_hw;
        n_total = r_total; n_scan = r_scan;
        ent_we = 1'b0; ent_waddr = '0; ent_wdata = '0; ent_raddr = '0;
        fs_we = 1'b0; fs_waddr = '0; fs_wdata = '0;
        fs_raddr = IDX_W'(r_fdepth - 1'b1);
        unique case (r_state)
            S_IDLE: begin
                n_scan = '0;
                ent_raddr = (i_data.op == OP_RELEASE) ? i_data.slot_index : '0;
                n_out = '0;
                n_out.live_slots = r_total;
                if (i_valid && i_data.op == OP_CLEAR) begin
                    n_fdepth = '0; n_hw = '0; n_total = '0;
                    n_out.live_slots = '0;
                end
            end
            S_SCAN: begin
                ent_raddr = IDX_W'(r_scan + 1'b1);
                n_scan = r_scan + 1'b1;
                if (hit) begin
                    ent_we = 1'b1; ent_waddr = scan_idx;
                    ent_wdata = {rd_key, (rd_refs == REF_MAX) ? rd_refs : rd_refs + 1'b1};
                    n_out.slot = scan_idx;
                    n_out.ref_count =
                        REF_BITS'((rd_refs == REF_MAX) ? rd_refs : rd_refs + 1'b1);
                end
            end
            S_POP: ; // free stack read in flight
            S_ALLOC: begin
                if (r_fdepth != '0) begin
                    n_fdepth = r_fdepth - 1'b1;
                end else if (r_hw < CNT_W'(SLOTS)) begin
                    n_hw = r_hw + 1'b1;
                end
                if (r_fdepth != '0 || r_hw < CNT_W'(SLOTS)) begin
                    ent_we = 1'b1;
                    ent_waddr = (r_fdepth != '0) ? fs_rdata : IDX_W'(r_hw);
                    ent_wdata = {r_in.key[KEY_BITS-1:0], REF_BITS'(1)};
                    n_total = r_total + 1'b1;
                    n_out.slot = ent_waddr;
                    n_out.created = 1'b1;
                    n_out.ref_count = REF_BITS'(1);
                    n_out.live_slots = r_total + 1'b1;
                end else begin
                    n_out.status = ST_FULL;
                end
            end
            S_REL: begin
                n_out.slot = r_in.slot_index;
                if (CNT_W'(r_in.slot_index) >= r_hw || rd_refs == '0) begin
                    n_out.status = ST_IGNORED;
                end else if (rd_refs > REF_BITS'(1)) begin
                    ent_we = 1'b1; ent_waddr = r_in.slot_index;
                    ent_wdata = {rd_key, rd_refs - 1'b1};
                    n_out.ref_count = REF_BITS'(rd_refs - 1'b1);
                end else begin
                    ent_we = 1'b1; ent_waddr = r_in.slot_index;
                    ent_wdata = {rd_key, REF_BITS'(0)};
                    n_total = r_total - 1'b1;
                    n_out.live_slots = r_total - 1'b1;
                    n_out.freed = 1'b1;
                    if (r_fdepth < CNT_W'(SLOTS)) begin
                        fs_we = 1'b1; fs_waddr = IDX_W'(r_fdepth);
                        fs_wdata = r_in.slot_index;
                        n_fdepth = r_fdepth + 1'b1;
                    end
                end
            end
            S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_fdepth <= '0; r_hw <= '0; r_total <= '0;
        end else begin
            r_state <= n_state; r_fdepth <= n_fdepth;
            r_hw <= n_hw; r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_in <= i_data;
        r_out <= n_out; r_scan <= n_scan;
    end
endmodule

### hw/rtl/rkst_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module rkst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
